// ----- sv/gha_pkg.sv -----
package gha_pkg;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NOT_LIVE = 2'd1;
	localparam logic [1:0] STATUS_FULL     = 2'd2;
	localparam logic [1:0] STATUS_NEVER    = 2'd3;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_REUSE,
		ACT_FRESH,
		ACT_FULL,
		ACT_FREE,
		ACT_NEVER
	} action_t;

	typedef struct packed {
		logic    accept;
		logic    gen_rd;
		logic    commit;
		action_t act;
	} cmd_t;

	typedef struct packed {
		logic fifo_nonempty;
		logic created_full;
		logic idx_never;
	} sts_t;

endpackage

// ----- sv/gha_ctrl.sv -----
module gha_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic          in_op,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	input  gha_pkg::sts_t sts,
	output gha_pkg::cmd_t cmd
);
	import gha_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_GEN_RD,
		S_FINISH
	} state_t;

	state_t  state_q;
	action_t act_q;
	logic    out_valid_q;
	logic    accept;
	logic    commit;
	action_t act_sel;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign commit        = (state_q == S_FINISH) && (!out_valid_q || m_axis_tready);

	always_comb begin
		if (in_op == OP_ALLOC) begin
			if (sts.fifo_nonempty)
				act_sel = ACT_REUSE;
			else if (sts.created_full)
				act_sel = ACT_FULL;
			else
				act_sel = ACT_FRESH;
		end else begin
			act_sel = sts.idx_never ? ACT_NEVER : ACT_FREE;
		end
	end

	always_comb begin
		cmd.accept = accept;
		cmd.gen_rd = (state_q == S_GEN_RD);
		cmd.commit = commit;
		cmd.act    = act_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			act_q       <= ACT_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (commit)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_q   <= act_sel;
						state_q <= (act_sel == ACT_REUSE) ? S_GEN_RD : S_FINISH;
					end
				end
				S_GEN_RD: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (commit) begin
						state_q <= S_IDLE;
						act_q   <= ACT_NONE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("new transaction taken while one is in flight");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> m_axis_tvalid)
		else $error("result register not loaded after commit");

	a_reuse_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GEN_RD) |-> (act_q == ACT_REUSE))
		else $error("generation read outside reuse");

endmodule

// ----- sv/gha_dp.sv -----
module gha_dp #(
	parameter int SLOTS     = 256,
	parameter int GEN_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    in_index,
	input  gha_pkg::cmd_t cmd,
	output gha_pkg::sts_t sts,
	output logic [7:0]    res_index,
	output logic [31:0]   res_generation,
	output logic [1:0]    res_status
);
	import gha_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

	function automatic logic [IDX_W-1:0] to_slot(input logic [7:0] v);
		logic [IDX_W+7:0] t;
		t = {{IDX_W{1'b0}}, v};
		return t[IDX_W-1:0];
	endfunction

	function automatic logic [7:0] to_byte(input logic [IDX_W-1:0] v);
		logic [IDX_W+7:0] t;
		t = {8'b0, v};
		return t[7:0];
	endfunction

	function automatic logic [31:0] to_gen32(input logic [GEN_WIDTH-1:0] v);
		logic [GEN_WIDTH+31:0] t;
		t = {32'b0, v};
		return t[31:0];
	endfunction

	logic [IDX_W-1:0]     fifo_mem [SLOTS];
	logic [GEN_WIDTH-1:0] gen_mem  [SLOTS];
	logic                 live_mem [SLOTS];

	logic [IDX_W-1:0]     head_q;
	logic [IDX_W-1:0]     tail_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     created_q;
	logic [7:0]           idx_q;
	logic [IDX_W-1:0]     slot_q;
	logic [IDX_W-1:0]     fifo_rd_q;
	logic [GEN_WIDTH-1:0] gen_rd_q;
	logic                 live_rd_q;

	logic [IDX_W-1:0]     in_slot;
	logic [IDX_W-1:0]     idx_slot;
	logic [IDX_W-1:0]     fresh_slot;
	logic [GEN_WIDTH-1:0] gen_next;
	logic                 do_reuse;
	logic                 do_fresh;
	logic                 free_ok;
	logic                 do_push;
	logic                 gen_we;
	logic [IDX_W-1:0]     gen_waddr;
	logic [GEN_WIDTH-1:0] gen_wdata;
	logic                 live_we;
	logic [IDX_W-1:0]     live_waddr;

	assign in_slot    = to_slot(in_index);
	assign idx_slot   = to_slot(idx_q);
	assign fresh_slot = created_q[IDX_W-1:0];
	assign gen_next   = gen_rd_q + GEN_WIDTH'(1);

	assign sts.fifo_nonempty = (count_q != '0);
	assign sts.created_full  = (created_q == CNT_W'(SLOTS));
	assign sts.idx_never     = (CMP_W'(in_index) >= CMP_W'(created_q)) ||
	                           (CMP_W'(in_index) >= CMP_W'(SLOTS));

	assign do_reuse = cmd.commit && (cmd.act == ACT_REUSE);
	assign do_fresh = cmd.commit && (cmd.act == ACT_FRESH);
	assign free_ok  = cmd.commit && (cmd.act == ACT_FREE) && live_rd_q;
	assign do_push  = free_ok && (count_q != CNT_W'(SLOTS));

	assign gen_we     = do_reuse || do_fresh;
	assign gen_waddr  = do_reuse ? slot_q : fresh_slot;
	assign gen_wdata  = do_reuse ? gen_next : '0;
	assign live_we    = gen_we || free_ok;
	assign live_waddr = free_ok ? idx_slot : gen_waddr;

	// free queue
	always_ff @(posedge clk) begin
		if (do_push)
			fifo_mem[tail_q] <= idx_slot;
		fifo_rd_q <= fifo_mem[head_q];
	end

	// generation store
	always_ff @(posedge clk) begin
		if (gen_we)
			gen_mem[gen_waddr] <= gen_wdata;
		if (cmd.gen_rd) begin
			gen_rd_q <= gen_mem[fifo_rd_q];
			slot_q   <= fifo_rd_q;
		end
	end

	// live flags
	always_ff @(posedge clk) begin
		if (live_we)
			live_mem[live_waddr] <= !free_ok;
		if (cmd.accept) begin
			live_rd_q <= live_mem[in_slot];
			idx_q     <= in_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			created_q <= '0;
		end else begin
			if (do_reuse) begin
				head_q  <= (head_q == IDX_W'(SLOTS - 1)) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
			if (do_push) begin
				tail_q  <= (tail_q == IDX_W'(SLOTS - 1)) ? '0 : tail_q + 1'b1;
				count_q <= count_q + 1'b1;
			end
			if (do_fresh)
				created_q <= created_q + 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			case (cmd.act)
				ACT_REUSE: begin
					res_index      <= to_byte(slot_q);
					res_generation <= to_gen32(gen_next);
					res_status     <= STATUS_OK;
				end
				ACT_FRESH: begin
					res_index      <= to_byte(fresh_slot);
					res_generation <= '0;
					res_status     <= STATUS_OK;
				end
				ACT_FREE: begin
					res_index      <= idx_q;
					res_generation <= '0;
					res_status     <= live_rd_q ? STATUS_OK : STATUS_NOT_LIVE;
				end
				ACT_NEVER: begin
					res_index      <= idx_q;
					res_generation <= '0;
					res_status     <= STATUS_NEVER;
				end
				default: begin
					res_index      <= '0;
					res_generation <= '0;
					res_status     <= STATUS_FULL;
				end
			endcase
		end
	end

	a_queue_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= created_q)
		else $error("more queued indices than slots created");

	a_created_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		created_q <= CNT_W'(SLOTS))
		else $error("slot counter past capacity");

	a_reuse_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		do_reuse |-> (count_q != '0))
		else $error("reuse with empty free queue");

endmodule

// ----- sv/generational_handle_allocator_unit.sv -----
// channel  dir  tdata                                   tuser
// s_axis   in   [7:0] slot_index                        [0] op
// m_axis   out  [7:0] handle_index, [39:8] generation   [1:0] status
//
// allocate from the free queue: queue head read, then generation read, then the finishing step
// fresh allocate, full, and any free: straight to the finishing step (live flag read on free)
// one transaction in flight; the next is taken while a result waits in the output register
// a stalled output holds the finishing step until the result register drains
// no clearing pass after reset; stores are only read where written
module generational_handle_allocator_unit #(
	parameter int SLOTS     = 256,
	parameter int GEN_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // slot_index
	input  logic        s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // handle_index, handle_generation
	output logic [1:0]  m_axis_tuser   // status
);
	import gha_pkg::*;

	cmd_t        cmd;
	sts_t        sts;
	logic [7:0]  res_index;
	logic [31:0] res_generation;
	logic [1:0]  res_status;

	gha_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.in_op         (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	gha_dp #(
		.SLOTS     (SLOTS),
		.GEN_WIDTH (GEN_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_index       (s_axis_tdata),
		.cmd            (cmd),
		.sts            (sts),
		.res_index      (res_index),
		.res_generation (res_generation),
		.res_status     (res_status)
	);

	assign m_axis_tdata = {res_generation, res_index};
	assign m_axis_tuser = res_status;

endmodule

// ----- sim/tb_generational_handle_allocator_unit.sv -----
typedef struct packed {
	logic [7:0]  slot;
	logic [31:0] gen;
	logic [1:0]  status;
} grant_t;

class allocator_ledger;
	logic [31:0] generation [256];
	bit          live [256];
	logic [7:0]  free_order [$];
	int          created;
	grant_t      pending [$];
	int          fails;

	function new();
		created = 0;
		fails = 0;
		foreach (generation[i]) begin
			generation[i] = '0;
			live[i] = 1'b0;
		end
	endfunction

	function void note_request(logic op, logic [7:0] idx);
		grant_t g;
		int s;
		g.slot = '0;
		g.gen = '0;
		g.status = gha_pkg::STATUS_OK;
		if (op == gha_pkg::OP_ALLOC) begin
			if (free_order.size() != 0) begin
				s = int'(free_order.pop_front());
				generation[s] = generation[s] + 32'd1;
				live[s] = 1'b1;
				g.slot = s[7:0];
				g.gen = generation[s];
			end else if (created < 256) begin
				generation[created] = '0;
				live[created] = 1'b1;
				g.slot = created[7:0];
				created++;
			end else begin
				g.status = gha_pkg::STATUS_FULL;
			end
		end else begin
			g.slot = idx;
			if (idx >= created) begin
				g.status = gha_pkg::STATUS_NEVER;
			end else if (!live[idx]) begin
				g.status = gha_pkg::STATUS_NOT_LIVE;
			end else begin
				free_order = {free_order, idx};
				live[idx] = 1'b0;
			end
		end
		pending = {pending, g};
	endfunction

	function void check_grant(logic [7:0] slot, logic [31:0] gen, logic [1:0] status);
		grant_t g;
		if (pending.size() == 0) begin
			if (fails < 10)
				$display("unexpected transaction: slot %0d gen %0d status %0d", slot, gen, status);
			fails++;
		end else begin
			g = pending.pop_front();
			if (slot !== g.slot || gen !== g.gen || status !== g.status) begin
				if (fails < 10)
					$display("mismatch: expected slot %0d gen %0d status %0d, got slot %0d gen %0d status %0d",
						g.slot, g.gen, g.status, slot, gen, status);
				fails++;
			end
		end
	endfunction

	function int find_slot(bit want_live);
		int start;
		int s;
		start = $urandom_range(0, 255);
		for (int i = 0; i < 256; i++) begin
			s = (start + i) % 256;
			if (s < created && live[s] == want_live)
				return s;
		end
		return -1;
	endfunction
endclass

module tb_generational_handle_allocator_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import gha_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;  // slot_index
	logic        s_axis_tuser;  // op
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;  // handle_index, handle_generation
	logic [1:0]  m_axis_tuser;  // status

	allocator_ledger ledger;
	bit calm;
	bit start_hold;

	generational_handle_allocator_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic send_request(input logic op, input logic [7:0] idx);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= idx;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		ledger.note_request(op, idx);
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 13);
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (ledger.pending.size() != 0) @(posedge clk);
	endtask

	// result side: check each transaction, then pick next tready
	initial begin
		int burst;
		int hold_left;
		burst = 0;
		hold_left = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				ledger.check_grant(m_axis_tdata[7:0], m_axis_tdata[39:8], m_axis_tuser);
			if (start_hold) begin
				start_hold = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (!calm && burst == 0 && $urandom_range(0, 9) == 0)
					burst = $urandom_range(1, 13);
				if (burst > 0) begin
					burst--;
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("tb_generational_handle_allocator_unit: FAIL");
		$finish;
	end

	initial begin
		int pct;
		int r;
		int k;
		int s;
		logic op;
		logic [7:0] idx;
		ledger = new();
		calm = 1'b0;
		start_hold = 1'b0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= OP_ALLOC;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// frees before anything exists, first fresh slots, double free, reuse order
		send_request(OP_FREE, 8'd0);
		send_request(OP_FREE, 8'd255);
		send_request(OP_ALLOC, 8'hff);
		send_request(OP_ALLOC, 8'h00);
		send_request(OP_FREE, 8'd1);
		send_request(OP_FREE, 8'd1);
		send_request(OP_FREE, 8'd2);
		send_request(OP_FREE, 8'd0);
		send_request(OP_ALLOC, 8'hff);
		send_request(OP_ALLOC, 8'h00);
		send_request(OP_FREE, 8'd0);
		send_request(OP_ALLOC, 8'h55);
		send_request(OP_ALLOC, 8'haa);
		send_request(OP_FREE, 8'haa);
		send_request(OP_FREE, 8'h55);
		send_request(OP_FREE, 8'd2);
		send_request(OP_FREE, 8'd2);
		s_axis_tvalid <= 1'b0;
		wait_drained();

		for (int seg = 0; seg < 16; seg++) begin
			calm = (seg >= 14);
			case (seg)
				2, 3, 4: pct = 95;
				9: pct = 15;
				default: pct = 30 + 20 * $urandom_range(0, 2);
			endcase
			if (seg == 5)
				start_hold = 1'b1;
			if (seg == 8) begin
				s_axis_tvalid <= 1'b0;
				wait_drained();
			end
			for (int n = 0; n < 100; n++) begin
				r = $urandom_range(0, 99);
				if (r < pct) begin
					op = OP_ALLOC;
					idx = 8'($urandom);
				end else begin
					op = OP_FREE;
					k = $urandom_range(0, 9);
					if (k < 7)
						s = ledger.find_slot(1'b1);
					else if (k < 8)
						s = ledger.find_slot(1'b0);
					else
						s = -1;
					idx = (s < 0) ? 8'($urandom) : s[7:0];
				end
				send_request(op, idx);
			end
		end
		s_axis_tvalid <= 1'b0;

		wait_drained();
		repeat (10) @(posedge clk);
		if (ledger.fails == 0 && ledger.pending.size() == 0)
			$display("tb_generational_handle_allocator_unit: PASS");
		else
			$display("tb_generational_handle_allocator_unit: FAIL");
		$finish;
	end
endmodule

// ----- generational_handle_allocator_unit.f -----
sv/gha_pkg.sv
sv/gha_ctrl.sv
sv/gha_dp.sv
sv/generational_handle_allocator_unit.sv
sim/tb_generational_handle_allocator_unit.sv
